[hdl/fcgi_pkg.sv]
// ----------------------------------------------------------------------------
// fcgi_pkg
// Shared types and constants of the FastCGI record parser.
// ----------------------------------------------------------------------------
package fcgi_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned RAW_LEN_W   = 31;

	localparam logic [7:0] TYPE_BEGIN  = 8'd1;
	localparam logic [7:0] TYPE_PARAMS = 8'd4;
	localparam logic [7:0] TYPE_STDIN  = 8'd5;

	typedef enum logic [4:0] {
		PH_H0, PH_H1, PH_H2, PH_H3, PH_H4, PH_H5, PH_H6, PH_H7,
		PH_BEGIN,
		PH_NL0, PH_NL2, PH_NL1, PH_NLL,
		PH_VL0, PH_VL2, PH_VL1, PH_VLL,
		PH_NAME, PH_VALUE, PH_STDIN, PH_SKIP, PH_PAD
	} phase_t;

	typedef enum logic [3:0] {
		KIND_HEADER, KIND_BEGIN, KIND_NAME_LEN, KIND_VALUE_LEN,
		KIND_NAME, KIND_VALUE, KIND_STDIN, KIND_PAD, KIND_IGNORED
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       long_len;
	} fcgi_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  echo;
		logic        field_last;
		logic        record_done;
		logic        error;
		logic [7:0]  rtype;
		logic [15:0] req_id;
		logic [15:0] clen;
		logic [15:0] role;
		logic [7:0]  flags;
	} fcgi_result_t;

endpackage

[hdl/fcgi_front.sv]
// ----------------------------------------------------------------------------
// fcgi_front
// Input register: accepts stream words and tags length-form bits.
// ----------------------------------------------------------------------------
module fcgi_front import fcgi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       f_valid,
	output fcgi_word_t f_word,
	input  logic       f_ready
);

	logic       valid_q;
	fcgi_word_t word_q;

	assign in_ready = !valid_q || f_ready;
	assign f_valid  = valid_q;
	assign f_word   = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q.data     <= data_byte;
			word_q.long_len <= data_byte[7];
		end
	end

endmodule

[hdl/fcgi_queue.sv]
// ----------------------------------------------------------------------------
// fcgi_queue
// Short word queue between the front register and the parser.
// ----------------------------------------------------------------------------
module fcgi_queue import fcgi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  fcgi_word_t push_word,
	output logic       pop_valid,
	input  logic       pop,
	output fcgi_word_t pop_word
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	fcgi_word_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_word   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[hdl/fcgi_back.sv]
// ----------------------------------------------------------------------------
// fcgi_back
// Record parser state machine with a registered result stage.
// ----------------------------------------------------------------------------
module fcgi_back import fcgi_pkg::*; #(
	parameter int unsigned PARAM_LEN_BITS = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  fcgi_word_t                q_word,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output fcgi_result_t              res,
	output logic [PARAM_LEN_BITS-1:0] param_length
);

	localparam int unsigned LW = PARAM_LEN_BITS;
	localparam logic [RAW_LEN_W-1:0] LEN_MAX =
		RAW_LEN_W'((64'd1 << PARAM_LEN_BITS) - 64'd1);

	phase_t                 phase_q, phase_d;
	logic [7:0]             type_q, type_d;
	logic [15:0]            rid_q, rid_d;
	logic [15:0]            clen_q, clen_d;
	logic [7:0]             pad_q, pad_d;
	logic [16:0]            cc_q, cc_d;
	logic [LW-1:0]          br_q, br_d;
	logic [RAW_LEN_W-1:0]   nl_q, nl_d;
	logic [RAW_LEN_W-1:0]   vl_q, vl_d;
	logic [15:0]            role_q, role_d;
	logic [7:0]             flags_q, flags_d;
	logic                   err_q, err_d;

	logic                   out_valid_q;
	fcgi_result_t           res_q;
	logic [LW-1:0]          plen_q;

	kind_t                  kind;
	logic                   flast;
	logic                   rdone;
	logic [RAW_LEN_W-1:0]   plen;
	logic                   last;
	logic                   pair_done;
	logic                   is_param;
	logic                   take;
	logic [7:0]             b;
	logic                   pad_zero;
	phase_t                 end_phase;
	logic [LW-1:0]          br_dec;

	function automatic logic [RAW_LEN_W-1:0] sat_len(input logic [RAW_LEN_W-1:0] v);
		return (v > LEN_MAX) ? LEN_MAX : v;
	endfunction

	assign take      = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = take;
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign param_length = plen_q;

	assign b         = q_word.data;
	assign pad_zero  = pad_q == 8'd0;
	assign end_phase = pad_zero ? PH_H0 : PH_PAD;
	assign last      = ({1'b0, cc_q} + 18'd1) >= {2'b00, clen_q};
	assign br_dec    = (br_q != '0) ? LW'(br_q - 1'b1) : br_q;

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		rid_d     = rid_q;
		clen_d    = clen_q;
		pad_d     = pad_q;
		cc_d      = cc_q;
		br_d      = br_q;
		nl_d      = nl_q;
		vl_d      = vl_q;
		role_d    = role_q;
		flags_d   = flags_q;
		err_d     = err_q;
		kind      = KIND_IGNORED;
		flast     = 1'b0;
		rdone     = 1'b0;
		plen      = '0;
		pair_done = 1'b0;
		is_param  = 1'b0;

		if (phase_q >= PH_BEGIN && phase_q <= PH_SKIP && cc_q != 17'h1FFFF) begin
			cc_d = 17'(cc_q + 1'b1);
		end

		unique case (phase_q)
			PH_H0: begin
				kind = KIND_HEADER; phase_d = PH_H1;
			end
			PH_H1: begin
				kind = KIND_HEADER; type_d = b; phase_d = PH_H2;
			end
			PH_H2: begin
				kind = KIND_HEADER; rid_d = {b, 8'd0}; phase_d = PH_H3;
			end
			PH_H3: begin
				kind = KIND_HEADER; rid_d = {rid_q[15:8], b}; phase_d = PH_H4;
			end
			PH_H4: begin
				kind = KIND_HEADER; clen_d = {b, 8'd0}; phase_d = PH_H5;
			end
			PH_H5: begin
				kind = KIND_HEADER; clen_d = {clen_q[15:8], b}; phase_d = PH_H6;
			end
			PH_H6: begin
				kind = KIND_HEADER; pad_d = b; phase_d = PH_H7;
			end
			PH_H7: begin
				kind = KIND_HEADER;
				cc_d = '0;
				priority if (clen_q == 16'd0) begin
					phase_d = end_phase;
					rdone   = pad_zero;
					if (!pad_zero) br_d = LW'(pad_q);
				end else if (type_q == TYPE_BEGIN) begin
					phase_d = PH_BEGIN;
				end else if (type_q == TYPE_PARAMS) begin
					phase_d = PH_NL0;
				end else if (type_q == TYPE_STDIN) begin
					phase_d = PH_STDIN;
				end else begin
					err_d   = 1'b1;
					phase_d = PH_SKIP;
				end
			end
			PH_BEGIN: begin
				kind = (cc_q < 17'd8) ? KIND_BEGIN : KIND_IGNORED;
				if (cc_q == 17'd0) role_d = {b, 8'd0};
				else if (cc_q == 17'd1) role_d = {role_q[15:8], b};
				else if (cc_q == 17'd2) flags_d = b;
				if (last) begin
					phase_d = end_phase;
					rdone   = pad_zero;
					if (!pad_zero) br_d = LW'(pad_q);
				end
			end
			PH_NL0: begin
				is_param = 1'b1; kind = KIND_NAME_LEN;
				if (q_word.long_len) begin
					nl_d    = {b[6:0], 24'd0};
					phase_d = PH_NL2;
				end else begin
					nl_d    = RAW_LEN_W'(b);
					flast   = 1'b1;
					phase_d = PH_VL0;
				end
				plen = nl_d;
			end
			PH_NL2: begin
				is_param = 1'b1; kind = KIND_NAME_LEN;
				nl_d = nl_q | {7'd0, b, 16'd0}; plen = nl_d; phase_d = PH_NL1;
			end
			PH_NL1: begin
				is_param = 1'b1; kind = KIND_NAME_LEN;
				nl_d = nl_q | {15'd0, b, 8'd0}; plen = nl_d; phase_d = PH_NLL;
			end
			PH_NLL: begin
				is_param = 1'b1; kind = KIND_NAME_LEN;
				nl_d = sat_len(nl_q | {23'd0, b}); plen = nl_d;
				flast = 1'b1; phase_d = PH_VL0;
			end
			PH_VL0, PH_VLL: begin
				is_param = 1'b1; kind = KIND_VALUE_LEN;
				if (phase_q == PH_VL0 && q_word.long_len) begin
					vl_d    = {b[6:0], 24'd0};
					phase_d = PH_VL2;
				end else begin
					vl_d  = (phase_q == PH_VL0) ? RAW_LEN_W'(b)
						: sat_len(vl_q | {23'd0, b});
					flast = 1'b1;
					if (nl_q != '0) begin
						phase_d = PH_NAME; br_d = LW'(nl_q);
					end else if (vl_d != '0) begin
						phase_d = PH_VALUE; br_d = LW'(vl_d);
					end else begin
						pair_done = 1'b1;
					end
				end
				plen = vl_d;
			end
			PH_VL2: begin
				is_param = 1'b1; kind = KIND_VALUE_LEN;
				vl_d = vl_q | {7'd0, b, 16'd0}; plen = vl_d; phase_d = PH_VL1;
			end
			PH_VL1: begin
				is_param = 1'b1; kind = KIND_VALUE_LEN;
				vl_d = vl_q | {15'd0, b, 8'd0}; plen = vl_d; phase_d = PH_VLL;
			end
			PH_NAME: begin
				is_param = 1'b1; kind = KIND_NAME; plen = nl_q;
				br_d = br_dec;
				if (br_dec == '0) begin
					flast = 1'b1;
					if (vl_q != '0) begin
						phase_d = PH_VALUE; br_d = LW'(vl_q);
					end else begin
						pair_done = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				is_param = 1'b1; kind = KIND_VALUE; plen = vl_q;
				br_d = br_dec;
				if (br_dec == '0) begin
					flast = 1'b1; pair_done = 1'b1;
				end
			end
			PH_STDIN: begin
				kind = KIND_STDIN;
				if (last) begin
					flast   = 1'b1;
					phase_d = end_phase;
					rdone   = pad_zero;
					if (!pad_zero) br_d = LW'(pad_q);
				end
			end
			PH_SKIP: begin
				kind = KIND_IGNORED;
				if (last) begin
					phase_d = end_phase;
					rdone   = pad_zero;
					if (!pad_zero) br_d = LW'(pad_q);
				end
			end
			PH_PAD: begin
				kind = KIND_PAD;
				if (br_q <= LW'(1)) begin
					br_d = '0; rdone = 1'b1; phase_d = PH_H0;
				end else begin
					br_d = LW'(br_q - 1'b1);
				end
			end
			default: begin
				kind = KIND_HEADER; phase_d = PH_H1;
			end
		endcase

		if (is_param) begin
			if (pair_done) phase_d = PH_NL0;
			if (last) begin
				if (!pair_done) err_d = 1'b1;
				phase_d = end_phase;
				rdone   = pad_zero;
				if (!pad_zero) br_d = LW'(pad_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_H0;
			type_q      <= '0;
			rid_q       <= '0;
			clen_q      <= '0;
			pad_q       <= '0;
			cc_q        <= '0;
			br_q        <= '0;
			nl_q        <= '0;
			vl_q        <= '0;
			role_q      <= '0;
			flags_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				type_q  <= type_d;
				rid_q   <= rid_d;
				clen_q  <= clen_d;
				pad_q   <= pad_d;
				cc_q    <= cc_d;
				br_q    <= br_d;
				nl_q    <= nl_d;
				vl_q    <= vl_d;
				role_q  <= role_d;
				flags_q <= flags_d;
				err_q   <= err_d;
			end
			out_valid_q <= take || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.kind        <= kind;
			res_q.echo        <= b;
			res_q.field_last  <= flast;
			res_q.record_done <= rdone;
			res_q.error       <= err_d;
			res_q.rtype       <= type_d;
			res_q.req_id      <= rid_d;
			res_q.clen        <= clen_d;
			res_q.role        <= role_d;
			res_q.flags       <= flags_d;
			plen_q            <= LW'(plen);
		end
	end

endmodule

[hdl/fastcgi_record_parser_core.sv]
// ----------------------------------------------------------------------------
// fastcgi_record_parser_core
// FastCGI record parser: classifies and echoes one stream octet per word.
// ----------------------------------------------------------------------------
// Takes one octet per cycle while in_ready is high and returns exactly one
// result word per octet, in order. A word passes an input register and a
// four-entry queue before the parser state machine, whose update of phase
// and counters sets the rate of one word per cycle unless the output holds;
// a result waits in an output register, and while it is not taken the parser
// stalls. Decoded parameter lengths saturate at 2^PARAM_LEN_BITS-1.
module fastcgi_record_parser_core import fcgi_pkg::*; #(
	parameter int unsigned PARAM_LEN_BITS = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3:0]                byte_kind,
	output logic [7:0]                echo_byte,
	output logic                      field_last,
	output logic                      record_done,
	output logic                      error_flag,
	output logic [7:0]                record_type,
	output logic [15:0]               record_id,
	output logic [15:0]               body_length,
	output logic [PARAM_LEN_BITS-1:0] param_length,
	output logic [15:0]               role,
	output logic [7:0]                begin_flags
);

	logic         f_valid;
	logic         f_ready;
	fcgi_word_t   f_word;
	logic         q_valid;
	logic         q_pop;
	fcgi_word_t   q_word;
	fcgi_result_t res;

	fcgi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.f_valid   (f_valid),
		.f_word    (f_word),
		.f_ready   (f_ready)
	);

	fcgi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_word  (f_word),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_word   (q_word)
	);

	fcgi_back #(
		.PARAM_LEN_BITS (PARAM_LEN_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_word       (q_word),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res          (res),
		.param_length (param_length)
	);

	assign byte_kind      = res.kind;
	assign echo_byte      = res.echo;
	assign field_last     = res.field_last;
	assign record_done    = res.record_done;
	assign error_flag     = res.error;
	assign record_type    = res.rtype;
	assign record_id      = res.req_id;
	assign body_length    = res.clen;
	assign role           = res.role;
	assign begin_flags    = res.flags;

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && error_flag |=> error_flag)
		else $error("error flag cleared");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_last |->
			(byte_kind == KIND_NAME_LEN || byte_kind == KIND_VALUE_LEN ||
			 byte_kind == KIND_NAME || byte_kind == KIND_VALUE ||
			 byte_kind == KIND_STDIN))
		else $error("field end on a non-field word");

	a_header_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_done && byte_kind == KIND_HEADER |->
			body_length == 16'd0)
		else $error("record ended in header with content");

endmodule

[tb/tb_fastcgi_record_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_fastcgi_record_parser_core
// Self-checking bench for the FastCGI record parser core.
// ----------------------------------------------------------------------------
// Builds a FastCGI octet stream from generated records: begin-request bodies of
// several sizes, parameter records with short and long length forms, stdin
// bodies, empty records and padding. Later parts add unknown record types and
// parameter overruns of the content. Every accepted octet runs through a
// cycle-free copy of the parser state machine, and every result word is
// compared field by field with the oldest prediction. Both handshakes idle in
// random bursts, and the output side holds off once long enough to back up
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fastcgi_record_parser_core import fcgi_pkg::*; ();

	localparam int unsigned LEN_W = 31;
	localparam longint unsigned MAX_LEN = (64'd1 << LEN_W) - 64'd1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_A_OCTETS = 950;
	localparam int unsigned PHASE_B_OCTETS = 1400;

	typedef struct packed {
		logic [3:0]       kind;
		logic [7:0]       echo;
		logic             flast;
		logic             rdone;
		logic             err;
		logic [7:0]       rtype;
		logic [15:0]      req_id;
		logic [15:0]      clen;
		logic [LEN_W-1:0] plen;
		logic [15:0]      role;
		logic [7:0]       flags;
	} parse_result_t;

	class parse_scoreboard;
		parse_result_t pending_words[$];
		int unsigned   n_in;
		int unsigned   n_out;
		int unsigned   n_fail;
		phase_t        ph;
		logic [7:0]    rtype;
		logic [15:0]   rid;
		logic [15:0]   clen;
		logic [7:0]    padlen;
		int unsigned   consumed;
		int unsigned   remaining;
		int unsigned   nlen;
		int unsigned   vlen;
		logic [15:0]   role_v;
		logic [7:0]    flags_v;
		bit            err;

		function new();
			ph = PH_H0;
			rtype = '0;
			rid = '0;
			clen = '0;
			padlen = '0;
			consumed = 0;
			remaining = 0;
			nlen = 0;
			vlen = 0;
			role_v = '0;
			flags_v = '0;
			err = 1'b0;
			n_in = 0;
			n_out = 0;
			n_fail = 0;
		endfunction

		function bit close_content();
			if (padlen == 8'd0) begin
				ph = PH_H0;
				return 1'b1;
			end
			ph = PH_PAD;
			remaining = 32'(padlen);
			return 1'b0;
		endfunction

		function bit route_pair();
			if (nlen > 0) begin
				ph = PH_NAME;
				remaining = nlen;
				return 1'b0;
			end
			if (vlen > 0) begin
				ph = PH_VALUE;
				remaining = vlen;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function int unsigned clamp_len(int unsigned v);
			return (v > MAX_LEN) ? 32'(MAX_LEN) : v;
		endfunction

		function parse_result_t decode_octet(logic [7:0] b);
			parse_result_t r;
			bit at_end;
			bit pair_done;
			bit in_pair;
			bit done;
			bit flast;
			int unsigned plen;
			int unsigned idx;
			r = '0;
			r.kind = KIND_IGNORED;
			at_end = 1'b0;
			pair_done = 1'b0;
			in_pair = 1'b0;
			done = 1'b0;
			flast = 1'b0;
			plen = 0;
			if (ph >= PH_BEGIN && ph <= PH_SKIP) begin
				at_end = (consumed + 1 >= clen);
				if (consumed < 32'h1FFFF)
					consumed++;
			end
			case (ph)
			PH_H0: begin
				r.kind = KIND_HEADER;
				ph = PH_H1;
			end
			PH_H1: begin
				r.kind = KIND_HEADER;
				rtype = b;
				ph = PH_H2;
			end
			PH_H2: begin
				r.kind = KIND_HEADER;
				rid = {b, 8'h00};
				ph = PH_H3;
			end
			PH_H3: begin
				r.kind = KIND_HEADER;
				rid[7:0] = b;
				ph = PH_H4;
			end
			PH_H4: begin
				r.kind = KIND_HEADER;
				clen = {b, 8'h00};
				ph = PH_H5;
			end
			PH_H5: begin
				r.kind = KIND_HEADER;
				clen[7:0] = b;
				ph = PH_H6;
			end
			PH_H6: begin
				r.kind = KIND_HEADER;
				padlen = b;
				ph = PH_H7;
			end
			PH_H7: begin
				r.kind = KIND_HEADER;
				consumed = 0;
				if (clen == 16'd0)
					done = close_content();
				else if (rtype == TYPE_BEGIN)
					ph = PH_BEGIN;
				else if (rtype == TYPE_PARAMS)
					ph = PH_NL0;
				else if (rtype == TYPE_STDIN)
					ph = PH_STDIN;
				else begin
					err = 1'b1;
					ph = PH_SKIP;
				end
			end
			PH_BEGIN: begin
				idx = consumed - 1;
				r.kind = (idx < 8) ? KIND_BEGIN : KIND_IGNORED;
				if (idx == 0)
					role_v = {b, 8'h00};
				else if (idx == 1)
					role_v[7:0] = b;
				else if (idx == 2)
					flags_v = b;
				if (at_end)
					done = close_content();
			end
			PH_NL0: begin
				in_pair = 1'b1;
				r.kind = KIND_NAME_LEN;
				if (b[7]) begin
					nlen = {1'b0, b[6:0], 24'd0};
					ph = PH_NL2;
				end else begin
					nlen = 32'(b);
					flast = 1'b1;
					ph = PH_VL0;
				end
				plen = nlen;
			end
			PH_NL2: begin
				in_pair = 1'b1;
				r.kind = KIND_NAME_LEN;
				nlen |= {8'd0, b, 16'd0};
				plen = nlen;
				ph = PH_NL1;
			end
			PH_NL1: begin
				in_pair = 1'b1;
				r.kind = KIND_NAME_LEN;
				nlen |= {16'd0, b, 8'd0};
				plen = nlen;
				ph = PH_NLL;
			end
			PH_NLL: begin
				in_pair = 1'b1;
				r.kind = KIND_NAME_LEN;
				nlen = clamp_len((nlen | b) & 32'h7FFF_FFFF);
				plen = nlen;
				flast = 1'b1;
				ph = PH_VL0;
			end
			PH_VL0: begin
				in_pair = 1'b1;
				r.kind = KIND_VALUE_LEN;
				if (b[7]) begin
					vlen = {1'b0, b[6:0], 24'd0};
					plen = vlen;
					ph = PH_VL2;
				end else begin
					vlen = 32'(b);
					plen = vlen;
					flast = 1'b1;
					pair_done = route_pair();
				end
			end
			PH_VL2: begin
				in_pair = 1'b1;
				r.kind = KIND_VALUE_LEN;
				vlen |= {8'd0, b, 16'd0};
				plen = vlen;
				ph = PH_VL1;
			end
			PH_VL1: begin
				in_pair = 1'b1;
				r.kind = KIND_VALUE_LEN;
				vlen |= {16'd0, b, 8'd0};
				plen = vlen;
				ph = PH_VLL;
			end
			PH_VLL: begin
				in_pair = 1'b1;
				r.kind = KIND_VALUE_LEN;
				vlen = clamp_len((vlen | b) & 32'h7FFF_FFFF);
				plen = vlen;
				flast = 1'b1;
				pair_done = route_pair();
			end
			PH_NAME: begin
				in_pair = 1'b1;
				r.kind = KIND_NAME;
				plen = nlen;
				if (remaining > 0)
					remaining--;
				if (remaining == 0) begin
					flast = 1'b1;
					if (vlen > 0) begin
						ph = PH_VALUE;
						remaining = vlen;
					end else
						pair_done = 1'b1;
				end
			end
			PH_VALUE: begin
				in_pair = 1'b1;
				r.kind = KIND_VALUE;
				plen = vlen;
				if (remaining > 0)
					remaining--;
				if (remaining == 0) begin
					flast = 1'b1;
					pair_done = 1'b1;
				end
			end
			PH_STDIN: begin
				r.kind = KIND_STDIN;
				if (at_end) begin
					flast = 1'b1;
					done = close_content();
				end
			end
			PH_SKIP: begin
				r.kind = KIND_IGNORED;
				if (at_end)
					done = close_content();
			end
			PH_PAD: begin
				r.kind = KIND_PAD;
				if (remaining <= 1) begin
					remaining = 0;
					done = 1'b1;
					ph = PH_H0;
				end else
					remaining--;
			end
			endcase
			if (in_pair) begin
				if (pair_done)
					ph = PH_NL0;
				if (at_end) begin
					if (!pair_done)
						err = 1'b1;
					done = close_content();
				end
			end
			r.echo = b;
			r.flast = flast;
			r.rdone = done;
			r.err = err;
			r.rtype = rtype;
			r.req_id = rid;
			r.clen = clen;
			r.plen = plen[LEN_W-1:0];
			r.role = role_v;
			r.flags = flags_v;
			return r;
		endfunction

		function void note_octet(logic [7:0] b);
			pending_words.push_back(decode_octet(b));
			n_in++;
		endfunction

		function void field_check(string fld, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				n_fail++;
				$display("%0t: word %0d %s mismatch: expected %0h, got %0h",
					$time, n_out, fld, want, got);
			end
		endfunction

		function void check_word(parse_result_t got);
			parse_result_t want;
			n_out++;
			if (pending_words.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected word: expected none, got kind %0h echo %0h",
					$time, got.kind, got.echo);
				return;
			end
			want = pending_words.pop_front();
			field_check("byte_kind", 32'(want.kind), 32'(got.kind));
			field_check("echo_byte", 32'(want.echo), 32'(got.echo));
			field_check("field_last", 32'(want.flast), 32'(got.flast));
			field_check("record_done", 32'(want.rdone), 32'(got.rdone));
			field_check("error_flag", 32'(want.err), 32'(got.err));
			field_check("record_type", 32'(want.rtype), 32'(got.rtype));
			field_check("record_id", 32'(want.req_id), 32'(got.req_id));
			field_check("body_length", 32'(want.clen), 32'(got.clen));
			field_check("param_length", 32'(want.plen), 32'(got.plen));
			field_check("role", 32'(want.role), 32'(got.role));
			field_check("begin_flags", 32'(want.flags), 32'(got.flags));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       data_byte;
	logic             out_valid;
	logic             out_ready;
	logic [3:0]       byte_kind;
	logic [7:0]       echo_byte;
	logic             field_last;
	logic             record_done;
	logic             error_flag;
	logic [7:0]       record_type;
	logic [15:0]      record_id;
	logic [15:0]      body_length;
	logic [LEN_W-1:0] param_length;
	logic [15:0]      role;
	logic [7:0]       begin_flags;

	parse_scoreboard sb = new();
	logic [7:0]      octet_q[$];
	logic [7:0]      body_q[$];
	int unsigned     n_octets = 0;
	int unsigned     n_begin_rec = 0;
	int unsigned     n_param_rec = 0;
	int unsigned     n_stdin_rec = 0;
	int unsigned     n_bad_rec = 0;
	int unsigned     cycle_cnt = 0;
	bit              tail_quiet = 1'b0;

	fastcgi_record_parser_core #(
		.PARAM_LEN_BITS(LEN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_kind(byte_kind),
		.echo_byte(echo_byte),
		.field_last(field_last),
		.record_done(record_done),
		.error_flag(error_flag),
		.record_type(record_type),
		.record_id(record_id),
		.body_length(body_length),
		.param_length(param_length),
		.role(role),
		.begin_flags(begin_flags)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	function automatic bit calm();
		return tail_quiet || ((cycle_cnt >> 8) % 4 == 3);
	endfunction

	function automatic void put_octet(logic [7:0] b);
		octet_q.push_back(b);
		n_octets++;
	endfunction

	function automatic void put_header(logic [7:0] ver, logic [7:0] rtype, logic [15:0] id,
			logic [15:0] clen, logic [7:0] pad);
		put_octet(ver);
		put_octet(rtype);
		put_octet(id[15:8]);
		put_octet(id[7:0]);
		put_octet(clen[15:8]);
		put_octet(clen[7:0]);
		put_octet(pad);
		put_octet(8'($urandom));
	endfunction

	function automatic void put_padding(logic [7:0] pad);
		repeat (pad) put_octet(8'($urandom));
	endfunction

	function automatic logic [7:0] pick_version();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd1;
	endfunction

	function automatic logic [15:0] pick_id();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'h0000;
		if (r < 10)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_pad();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'd0;
		if (r < 98)
			return 8'($urandom_range(1, 7));
		return 8'hFF;
	endfunction

	function automatic int unsigned pick_param_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 8);
		if (r < 88)
			return $urandom_range(9, 40);
		return $urandom_range(128, 200);
	endfunction

	function automatic void put_param_len(int unsigned n);
		if (n > 127 || $urandom_range(0, 4) == 0) begin
			body_q.push_back({1'b1, n[30:24]});
			body_q.push_back(n[23:16]);
			body_q.push_back(n[15:8]);
			body_q.push_back(n[7:0]);
		end else
			body_q.push_back(n[7:0]);
	endfunction

	function automatic void add_begin_record();
		int unsigned n;
		logic [7:0] pad;
		n = $urandom_range(0, 99);
		if (n < 5)
			n = 0;
		else if (n < 70)
			n = 8;
		else
			n = $urandom_range(1, 14);
		pad = pick_pad();
		put_header(pick_version(), TYPE_BEGIN, pick_id(), 16'(n), pad);
		repeat (n) put_octet(8'($urandom));
		put_padding(pad);
		n_begin_rec++;
	endfunction

	function automatic void add_stdin_record();
		int unsigned n;
		logic [7:0] pad;
		n = $urandom_range(0, 9);
		if (n == 0)
			n = 0;
		else if (n == 9)
			n = $urandom_range(100, 300);
		else
			n = $urandom_range(1, 24);
		pad = pick_pad();
		put_header(pick_version(), TYPE_STDIN, pick_id(), 16'(n), pad);
		repeat (n) put_octet(8'($urandom));
		put_padding(pad);
		n_stdin_rec++;
	endfunction

	function automatic void add_params_record(bit overrun);
		int unsigned pairs;
		int unsigned len_n;
		int unsigned len_v;
		int unsigned cut;
		logic [7:0] pad;
		body_q.delete();
		pairs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		repeat (pairs) begin
			len_n = pick_param_len();
			len_v = pick_param_len();
			put_param_len(len_n);
			put_param_len(len_v);
			repeat (len_n + len_v) body_q.push_back(8'($urandom));
		end
		cut = body_q.size();
		if (overrun) begin
			if (cut > 1 && $urandom_range(0, 1) == 1)
				cut = $urandom_range(1, cut - 1);
			else begin
				// saturated name length and a random long value length; end inside the name
				repeat (4) body_q.push_back(8'hFF);
				body_q.push_back({1'b1, 7'($urandom)});
				repeat (3) body_q.push_back(8'($urandom));
				repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom));
				cut = body_q.size();
			end
			n_bad_rec++;
		end else
			n_param_rec++;
		pad = pick_pad();
		put_header(pick_version(), TYPE_PARAMS, pick_id(), 16'(cut), pad);
		for (int i = 0; i < cut; i++)
			put_octet(body_q[i]);
		put_padding(pad);
	endfunction

	function automatic void add_unknown_record();
		logic [7:0] t;
		logic [7:0] pad;
		int unsigned n;
		do
			t = 8'($urandom);
		while (t == TYPE_BEGIN || t == TYPE_PARAMS || t == TYPE_STDIN);
		n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
		pad = pick_pad();
		put_header(pick_version(), t, pick_id(), 16'(n), pad);
		repeat (n) put_octet(8'($urandom));
		put_padding(pad);
		n_bad_rec++;
	endfunction

	function automatic void add_record(bit broken);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (broken && r < 20)
			add_unknown_record();
		else if (broken && r < 40)
			add_params_record(1'b1);
		else begin
			r = $urandom_range(0, 99);
			if (r < 25)
				add_begin_record();
			else if (r < 65)
				add_params_record(1'b0);
			else
				add_stdin_record();
		end
	endfunction

	task automatic send_stream();
		logic [7:0] b;
		while (octet_q.size() > 0) begin
			b = octet_q.pop_front();
			if (!calm() && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= b;
			@(posedge clk);
			while (in_ready !== 1'b1) @(posedge clk);
			sb.note_octet(b);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending_words.size() != 0) @(posedge clk);
	endtask

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d words outstanding", $time, sb.pending_words.size());
		$display("tb_fastcgi_record_parser_core failed");
		$finish;
	end

	initial begin : receiver
		parse_result_t got;
		int unsigned hold_left;
		bit long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got.kind = byte_kind;
				got.echo = echo_byte;
				got.flast = field_last;
				got.rdone = record_done;
				got.err = error_flag;
				got.rtype = record_type;
				got.req_id = record_id;
				got.clen = body_length;
				got.plen = param_length;
				got.role = role;
				got.flags = begin_flags;
				sb.check_word(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && sb.n_in >= 300) begin
				// hold off long enough to back up the input side
				long_hold_done = 1'b1;
				hold_left = 79;
				out_ready <= 1'b0;
			end else if (!calm() && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 9);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty record ending on its reserved byte, odd version
		put_header(8'hFF, TYPE_STDIN, 16'h0000, 16'd0, 8'd0);
		// begin body with role and flags at their top values
		put_header(8'h01, TYPE_BEGIN, 16'hFFFF, 16'd8, 8'd0);
		repeat (3) put_octet(8'hFF);
		repeat (5) put_octet(8'h00);
		// long-form name length with empty value, then empty name with a value
		put_header(8'h01, TYPE_PARAMS, 16'h0001, 16'd9, 8'd1);
		put_octet(8'h80);
		put_octet(8'h00);
		put_octet(8'h00);
		put_octet(8'h01);
		put_octet(8'h00);
		put_octet(8'h6E);
		put_octet(8'h00);
		put_octet(8'h01);
		put_octet(8'h76);
		put_octet(8'h00);
		send_stream();
		wait_drained();

		while (n_octets < PHASE_A_OCTETS)
			add_record(1'b0);
		send_stream();
		wait_drained();

		add_unknown_record();
		add_params_record(1'b1);
		while (n_octets < PHASE_B_OCTETS)
			add_record(1'b1);
		send_stream();
		wait_drained();

		tail_quiet = 1'b1;
		repeat (3) add_record(1'b0);
		put_header(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		n_bad_rec++;
		repeat (40) put_octet(8'($urandom));
		send_stream();
		wait_drained();
		repeat (16) @(posedge clk);

		$display("Covered %0d octets: %0d begin, %0d params, %0d stdin, %0d broken records.",
			n_octets, n_begin_rec, n_param_rec, n_stdin_rec, n_bad_rec);
		$display("Checked %0d result words, %0d field mismatches.", sb.n_out, sb.n_fail);
		if (sb.n_fail == 0 && sb.pending_words.size() == 0)
			$display("tb_fastcgi_record_parser_core passed");
		else
			$display("tb_fastcgi_record_parser_core failed");
		$finish;
	end

endmodule
